>>> hw/rtl/vrlrd_pkg.sv
// shared types, symbol codes and symbol classification for the voted run-length line decoder
package vrlrd_pkg;

  // input word: three redundant copies of one code symbol
  typedef struct packed {
    logic [7:0] copy_a;
    logic [7:0] copy_b;
    logic [7:0] copy_c;
  } in_word_t;

  // output word: one decoded character or event
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic [2:0] status;
    logic       stream_done;
    logic       last;
  } out_word_t;

  // status codes
  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StUnknown = 3'd1;
  localparam logic [2:0] StVote    = 3'd2;
  localparam logic [2:0] StMissing = 3'd3;
  localparam logic [2:0] StFull    = 3'd4;
  localparam logic [2:0] StTrunc   = 3'd5;

  // symbol codes and ranges
  localparam logic [7:0] SymEnd         = 8'd0;
  localparam logic [7:0] SymLineFirst   = 8'd1;
  localparam logic [7:0] SymNewline     = 8'd10;
  localparam logic [7:0] SymDoubleFirst = 8'd28;
  localparam logic [7:0] SymDoubleLast  = 8'd37;
  localparam logic [7:0] SymShiftFirst  = 8'd38;
  localparam logic [7:0] SymShiftLast   = 8'd47;
  localparam logic [7:0] SymEquals      = 8'd61;
  localparam logic [7:0] SymCapFirst    = 8'd65;
  localparam logic [7:0] SymCapLast     = 8'd90;
  localparam logic [7:0] SymVoteFail    = 8'd94;
  localparam logic [7:0] SymLowFirst    = 8'd97;
  localparam logic [7:0] SymLowLast     = 8'd122;
  localparam logic [7:0] SymRunTen      = 8'd126;
  localparam logic [7:0] RunMin         = 8'd3;
  localparam logic [7:0] RunMax         = 8'd28;
  localparam logic [4:0] RunTenLen      = 5'd10;

  // character offsets
  localparam logic [7:0] CaseOffset   = 8'd32;
  localparam logic [7:0] DigitOffset  = 8'd10;
  localparam logic [7:0] DoubleOffset = 8'd20;

  function automatic logic is_shift_digit(logic [7:0] s);
    return (s >= SymShiftFirst) && (s <= SymShiftLast);
  endfunction

  function automatic logic is_lower(logic [7:0] s);
    return (s >= SymLowFirst) && (s <= SymLowLast);
  endfunction

  function automatic logic is_capital(logic [7:0] s);
    return (s >= SymCapFirst) && (s <= SymCapLast);
  endfunction

  function automatic logic is_double_digit(logic [7:0] s);
    return (s >= SymDoubleFirst) && (s <= SymDoubleLast);
  endfunction

  // symbols that wait for the next one
  function automatic logic is_deferred(logic [7:0] s);
    return is_shift_digit(s) || is_lower(s) || (s == SymEquals);
  endfunction

  // run length carried by a symbol, zero when it is no count
  function automatic logic [4:0] run_length(logic [7:0] s);
    logic [4:0] len;
    len = 5'd0;
    if ((s >= RunMin) && (s <= RunMax) && (s != SymNewline)) begin
      len = s[4:0];
    end else if (s == SymRunTen) begin
      len = RunTenLen;
    end
    return len;
  endfunction

  // character repeated by a pending run symbol
  function automatic logic [7:0] run_char(logic [7:0] p);
    return is_shift_digit(p) ? (p + DigitOffset) : (p - CaseOffset);
  endfunction

endpackage

>>> hw/rtl/vrlrd_ram.sv
// generic single write port, single read port ram with registered read data
module vrlrd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/voted_rle_line_repeat_decoder_unit.sv
// top level: voted symbol decoder with run expansion and line replay from a history ram
//
// Each input word carries three copies of a code symbol; a two-of-three vote picks the symbol
// and the word is expanded into result words, one per decoded character or event, the last
// one flagged. A small sequencer drives one shared step counter and compare that pace every
// loop: a run, a repeated digit, a letter pair and a line replay. A plain symbol is accepted
// and then decoded, and a double digit is decoded into a repeated digit. A word that follows
// a run symbol is accepted and dispatched, then emits its characters one by one and, when it
// carries no run length, is decoded itself and may be held for the next word; a missing or
// disagreed line number is reported from dispatch. A line replay is accepted and dispatched,
// looks up the line table, then takes an address step and a registered history ram read for
// each copied character and a closing history read. Back-pressure stalls every step that
// emits. The next word is accepted once the last result of the previous one sits in the output
// register. The history and line table rams need no clearing after reset. After the end symbol
// every word is taken and dropped.
module voted_rle_line_repeat_decoder_unit #(
  parameter int unsigned HISTORY_DEPTH    = 1024,
  parameter int unsigned LINE_LIMIT       = 64,
  parameter int unsigned LINE_TABLE_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  vrlrd_pkg::in_word_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output vrlrd_pkg::out_word_t out_data_o
);

  localparam int unsigned HistAw = $clog2(HISTORY_DEPTH);
  localparam int unsigned FillW  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned LtAw   = $clog2(LINE_TABLE_DEPTH);
  localparam int unsigned TotW   = $clog2(LINE_TABLE_DEPTH + 1);
  localparam int unsigned CntW   = ($clog2(LINE_LIMIT + 1) > 5) ? $clog2(LINE_LIMIT + 1) : 5;
  localparam int unsigned NumW   = (TotW > 8) ? TotW : 8;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DISPATCH = 8'b0000_0010,
    S_RUN      = 8'b0000_0100,
    S_PRE      = 8'b0000_1000,
    S_DECODE   = 8'b0001_0000,
    S_RP_LINE  = 8'b0010_0000,
    S_RP_ADDR  = 8'b0100_0000,
    S_RP_DATA  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [7:0]       sym_q, sym_d;
  logic             bad_q, bad_d;
  logic [7:0]       pend_sym_q, pend_sym_d;
  logic             pend_vld_q, pend_vld_d;
  logic             fin_q, fin_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [TotW-1:0]  total_q, total_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [FillW-1:0] pos_q, pos_d;
  logic [FillW-1:0] end_q, end_d;
  logic [7:0]       stage_q, stage_d;
  logic             out_vld_q, out_vld_d;
  vrlrd_pkg::out_word_t out_q, out_d;

  // vote
  logic [7:0] vote_sym;
  logic       vote_bad;

  always_comb begin
    vote_bad = 1'b0;
    if ((in_data_i.copy_a == in_data_i.copy_b) || (in_data_i.copy_a == in_data_i.copy_c)) begin
      vote_sym = in_data_i.copy_a;
    end else if (in_data_i.copy_b == in_data_i.copy_c) begin
      vote_sym = in_data_i.copy_b;
    end else begin
      vote_sym = vrlrd_pkg::SymVoteFail;
      vote_bad = 1'b1;
    end
  end

  // history and line table rams
  logic [7:0]       hist_rdata;
  logic [FillW-1:0] lt_rdata;
  logic             hist_we;
  logic             lt_we;
  logic [FillW-1:0] fill_inc;
  logic [TotW-1:0]  total_inc;
  logic [7:0]       num_m1;

  assign fill_inc  = fill_q + FillW'(1);
  assign total_inc = total_q + TotW'(1);
  assign num_m1    = sym_q - 8'd1;

  vrlrd_ram #(
    .Width (8),
    .Depth (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (fill_q[HistAw-1:0]),
    .wdata_i (out_d.out_char),
    .raddr_i (pos_q[HistAw-1:0]),
    .rdata_o (hist_rdata)
  );

  vrlrd_ram #(
    .Width (FillW),
    .Depth (LINE_TABLE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (lt_we),
    .waddr_i (total_inc[LtAw-1:0]),
    .wdata_i (fill_inc),
    .raddr_i (LtAw'(num_m1)),
    .rdata_o (lt_rdata)
  );

  // shared step counter compare
  logic [4:0]      run_len;
  logic [CntW-1:0] lim;
  logic [CntW-1:0] cnt_inc;
  logic            cnt_at_lim;
  logic [7:0]      run_ch;

  assign run_len    = vrlrd_pkg::run_length(sym_q);
  assign run_ch     = vrlrd_pkg::run_char(pend_sym_q);
  assign cnt_inc    = cnt_q + CntW'(1);
  assign cnt_at_lim = (cnt_q == lim);

  always_comb begin
    unique case (state_q)
      S_RUN:     lim = CntW'(run_len) - CntW'(1);
      S_PRE:     lim = vrlrd_pkg::is_lower(pend_sym_q) ? CntW'(1) : '0;
      S_RP_DATA: lim = CntW'(LINE_LIMIT);
      default:   lim = CntW'(1);
    endcase
  end

  // decode helpers
  logic slot_free;
  logic dec_silent;
  logic line_missing;
  logic rp_cont;
  logic has_room;

  assign slot_free    = !out_vld_q || out_ready_i;
  assign dec_silent   = !bad_q && (sym_q != vrlrd_pkg::SymEnd) && vrlrd_pkg::is_deferred(sym_q);
  assign line_missing = (sym_q == '0) || (NumW'(sym_q) > NumW'(total_q));
  assign rp_cont      = (pos_q < end_q) && (hist_rdata != vrlrd_pkg::SymNewline);
  assign has_room     = (fill_q != FillW'(HISTORY_DEPTH));

  // emit request from the sequencer
  logic       em_req;
  logic [7:0] em_char;
  logic       em_valid;
  logic [2:0] em_status;
  logic       em_done;
  logic       em_store;
  logic       em_last;
  logic       em_go;

  assign em_go = em_req && slot_free;

  // sequencer
  always_comb begin
    state_d    = state_q;
    sym_d      = sym_q;
    bad_d      = bad_q;
    pend_sym_d = pend_sym_q;
    pend_vld_d = pend_vld_q;
    fin_d      = fin_q;
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    end_d      = end_q;
    stage_d    = stage_q;
    em_req     = 1'b0;
    em_char    = '0;
    em_valid   = 1'b0;
    em_status  = vrlrd_pkg::StOk;
    em_done    = 1'b0;
    em_store   = 1'b0;
    em_last    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (in_valid_i && !fin_q) begin
          sym_d   = vote_sym;
          bad_d   = vote_bad;
          state_d = pend_vld_q ? S_DISPATCH : S_DECODE;
        end
      end
      S_DISPATCH: begin
        cnt_d = '0;
        if (pend_sym_q == vrlrd_pkg::SymEquals) begin
          if (bad_q || line_missing) begin
            em_req    = 1'b1;
            em_status = bad_q ? vrlrd_pkg::StVote : vrlrd_pkg::StMissing;
            em_last   = 1'b1;
            if (slot_free) begin
              pend_vld_d = 1'b0;
              state_d    = S_IDLE;
            end
          end else begin
            pend_vld_d = 1'b0;
            state_d    = S_RP_LINE;
          end
        end else begin
          pend_vld_d = 1'b0;
          state_d    = (run_len != '0) ? S_RUN : S_PRE;
        end
      end
      S_RUN: begin
        em_req   = 1'b1;
        em_char  = run_ch;
        em_valid = 1'b1;
        em_store = 1'b1;
        em_last  = cnt_at_lim;
        if (slot_free) begin
          cnt_d = cnt_inc;
          if (cnt_at_lim) begin
            state_d = S_IDLE;
          end
        end
      end
      S_PRE: begin
        em_req   = 1'b1;
        em_char  = run_ch;
        em_valid = 1'b1;
        em_store = 1'b1;
        em_last  = cnt_at_lim && dec_silent;
        if (slot_free) begin
          if (cnt_at_lim) begin
            cnt_d   = '0;
            state_d = S_DECODE;
          end else begin
            cnt_d = cnt_inc;
          end
        end
      end
      S_DECODE: begin
        priority if (sym_q == vrlrd_pkg::SymEnd) begin
          em_req  = 1'b1;
          em_done = 1'b1;
          em_last = 1'b1;
          if (slot_free) begin
            fin_d   = 1'b1;
            state_d = S_IDLE;
          end
        end else if (bad_q) begin
          em_req    = 1'b1;
          em_char   = vrlrd_pkg::SymVoteFail;
          em_valid  = 1'b1;
          em_status = vrlrd_pkg::StVote;
          em_last   = 1'b1;
          if (slot_free) begin
            state_d = S_IDLE;
          end
        end else if (vrlrd_pkg::is_capital(sym_q) || (sym_q == vrlrd_pkg::SymNewline)) begin
          em_req   = 1'b1;
          em_char  = sym_q;
          em_valid = 1'b1;
          em_store = 1'b1;
          em_last  = 1'b1;
          if (slot_free) begin
            state_d = S_IDLE;
          end
        end else if (vrlrd_pkg::is_deferred(sym_q)) begin
          pend_sym_d = sym_q;
          pend_vld_d = 1'b1;
          state_d    = S_IDLE;
        end else if (vrlrd_pkg::is_double_digit(sym_q)) begin
          em_req   = 1'b1;
          em_char  = sym_q + vrlrd_pkg::DoubleOffset;
          em_valid = 1'b1;
          em_store = 1'b1;
          em_last  = cnt_at_lim;
          if (slot_free) begin
            cnt_d = cnt_inc;
            if (cnt_at_lim) begin
              state_d = S_IDLE;
            end
          end
        end else begin
          em_req    = 1'b1;
          em_char   = sym_q;
          em_valid  = 1'b1;
          em_status = vrlrd_pkg::StUnknown;
          em_last   = 1'b1;
          if (slot_free) begin
            state_d = S_IDLE;
          end
        end
      end
      S_RP_LINE: begin
        // line one starts at the bottom of the history
        pos_d   = (sym_q == vrlrd_pkg::SymLineFirst) ? '0 : lt_rdata;
        end_d   = fill_q;
        cnt_d   = '0;
        state_d = S_RP_ADDR;
      end
      S_RP_ADDR: begin
        state_d = S_RP_DATA;
      end
      S_RP_DATA: begin
        // the staged character goes out once the next one is known
        if (cnt_at_lim) begin
          em_req    = 1'b1;
          em_char   = stage_q;
          em_valid  = 1'b1;
          em_store  = 1'b1;
          em_status = rp_cont ? vrlrd_pkg::StTrunc : vrlrd_pkg::StOk;
          em_last   = 1'b1;
          if (slot_free) begin
            state_d = S_IDLE;
          end
        end else if (rp_cont) begin
          if (cnt_q == '0) begin
            stage_d = hist_rdata;
            cnt_d   = cnt_inc;
            pos_d   = pos_q + FillW'(1);
            state_d = S_RP_ADDR;
          end else begin
            em_req   = 1'b1;
            em_char  = stage_q;
            em_valid = 1'b1;
            em_store = 1'b1;
            if (slot_free) begin
              stage_d = hist_rdata;
              cnt_d   = cnt_inc;
              pos_d   = pos_q + FillW'(1);
              state_d = S_RP_ADDR;
            end
          end
        end else if (cnt_q != '0) begin
          em_req   = 1'b1;
          em_char  = stage_q;
          em_valid = 1'b1;
          em_store = 1'b1;
          em_last  = 1'b1;
          if (slot_free) begin
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // history append, line bookkeeping and output word
  always_comb begin
    fill_d    = fill_q;
    total_d   = total_q;
    hist_we   = 1'b0;
    lt_we     = 1'b0;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    out_d.out_char    = em_char;
    out_d.char_valid  = em_valid;
    out_d.status      = em_status;
    out_d.stream_done = em_done;
    out_d.last        = em_last;
    if (em_store && !has_room && (em_status == vrlrd_pkg::StOk)) begin
      out_d.status = vrlrd_pkg::StFull;
    end
    if (em_go && em_store && has_room) begin
      hist_we = 1'b1;
      fill_d  = fill_inc;
      if ((em_char == vrlrd_pkg::SymNewline) && (total_q != TotW'(LINE_TABLE_DEPTH))) begin
        total_d = total_inc;
        lt_we   = (total_inc != TotW'(LINE_TABLE_DEPTH));
      end
    end
    if (em_go) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pend_vld_q <= 1'b0;
      fin_q      <= 1'b0;
      fill_q     <= '0;
      total_q    <= '0;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      pend_vld_q <= pend_vld_d;
      fin_q      <= fin_d;
      fill_q     <= fill_d;
      total_q    <= total_d;
      cnt_q      <= cnt_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sym_q      <= sym_d;
    bad_q      <= bad_d;
    pend_sym_q <= pend_sym_d;
    pos_q      <= pos_d;
    end_q      <= end_d;
    stage_q    <= stage_d;
    if (em_go) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // a word taken after the end symbol leaves the sequencer idle
  a_drop_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && fin_q) |=> (state_q == S_IDLE))
    else $error("word after end symbol started work");

  // the history grows by at most one character a cycle
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> (fill_q == $past(fill_inc)))
    else $error("history fill jumped");

  // replay reads stay inside the history as it stood when the replay began
  a_replay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RP_DATA) |-> ((pos_q <= end_q) && (end_q <= fill_q)))
    else $error("replay position out of range");

  // the end-of-stream word is always the final word of its input
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (em_go && em_done) |-> (em_last && !em_valid))
    else $error("end-of-stream word not final");

endmodule
